// ===== rtl/core/sgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Swipe gesture detector package
// Event kinds, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package sgd_pkg;

    // field widths
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned ENABLE_W = 2;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned CMP_W    = VALUE_W + 1;

    // event kinds carried in the input tuser
    localparam logic [MODE_W-1:0] MODE_SLOT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRACK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POS_X   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POS_Y   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd5;

    // tracking id that marks a lifted finger
    localparam logic signed [VALUE_W-1:0] TRACK_ID_NONE = -16'sd1;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_DETECT_ENABLE  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_BOTTOM_Y_LIMIT = 3'd1;
    localparam logic [INDEX_W-1:0] REG_X_SPAN_MAX     = 3'd2;
    localparam logic [INDEX_W-1:0] REG_X_BAND_WIDTH   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_X_FINAL_EDGE   = 3'd4;

    // register reset values
    localparam logic [ENABLE_W-1:0] RST_DETECT_ENABLE  = 2'd2;
    localparam logic [COORD_W-1:0]  RST_BOTTOM_Y_LIMIT = 12'd3795;
    localparam logic [COORD_W-1:0]  RST_X_SPAN_MAX     = 12'd4080;
    localparam logic [COORD_W-1:0]  RST_X_BAND_WIDTH   = 12'd1000;
    localparam logic [COORD_W-1:0]  RST_X_FINAL_EDGE   = 12'd600;

    // configuration set seen by the gate logic
    typedef struct packed {
        logic [ENABLE_W-1:0] detect_enable;
        logic [COORD_W-1:0]  bottom_y_limit;
        logic [COORD_W-1:0]  x_span_max;
        logic [COORD_W-1:0]  x_band_width;
        logic [COORD_W-1:0]  x_final_edge;
    } sgd_cfg_t;

    // per-touch gate state
    typedef struct packed {
        logic first_gate;
        logic second_gate;
        logic fire_armed;
        logic touch_flag;
    } sgd_gates_t;

endpackage

// ===== rtl/core/sgd_gate_eval.sv =====
// ----------------------------------------------------------------------------
// Swipe gate evaluation
// Checks one held point against the three swipe gates and returns the
// updated gate state and the fire flag.
// ----------------------------------------------------------------------------
module sgd_gate_eval
    import sgd_pkg::*;
(
    input  logic signed [VALUE_W-1:0] x,
    input  logic signed [VALUE_W-1:0] y,
    input  sgd_cfg_t                  cfg,
    input  logic                      screen_asleep,
    input  sgd_gates_t                gates_in,
    output sgd_gates_t                gates_out,
    output logic                      fire
);

    logic signed [CMP_W-1:0] x_ext;
    logic signed [CMP_W-1:0] y_ext;
    logic signed [CMP_W-1:0] limit_ext;
    logic signed [CMP_W-1:0] span_ext;
    logic signed [CMP_W-1:0] band_ext;
    logic signed [CMP_W-1:0] final_ext;
    logic signed [CMP_W-1:0] outer_bound;
    logic signed [CMP_W-1:0] mid_bound;
    logic                    low;
    logic                    pass_one;
    logic                    pass_two;
    logic                    pass_three;

    // widen everything to one signed compare width so bounds never wrap
    assign x_ext       = CMP_W'(x);
    assign y_ext       = CMP_W'(y);
    assign limit_ext   = $signed({{(CMP_W-COORD_W){1'b0}}, cfg.bottom_y_limit});
    assign span_ext    = $signed({{(CMP_W-COORD_W){1'b0}}, cfg.x_span_max});
    assign band_ext    = $signed({{(CMP_W-COORD_W){1'b0}}, cfg.x_band_width});
    assign final_ext   = $signed({{(CMP_W-COORD_W){1'b0}}, cfg.x_final_edge});
    assign outer_bound = span_ext - final_ext;
    assign mid_bound   = span_ext - band_ext;

    // gate conditions
    assign low        = y_ext > limit_ext;
    assign pass_one   = gates_in.first_gate ||
                        ((x_ext < outer_bound) && (x_ext > mid_bound) && low);
    assign pass_two   = gates_in.second_gate ||
                        ((x_ext < mid_bound) && (x_ext > band_ext) && low);
    assign pass_three = (x_ext < band_ext) && low && (x_ext < final_ext) &&
                        gates_in.fire_armed;

    // gates only advance while detection runs and the screen is awake
    always_comb begin
        gates_out = gates_in;
        fire      = 1'b0;
        if ((cfg.detect_enable != '0) && !screen_asleep) begin
            gates_out.touch_flag = 1'b1;
            if (pass_one) begin
                gates_out.first_gate = 1'b1;
                if (pass_two) begin
                    gates_out.second_gate = 1'b1;
                    if (pass_three) begin
                        fire                 = 1'b1;
                        gates_out.fire_armed = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/swipe_gesture_detector_top.sv =====
// ----------------------------------------------------------------------------
// Swipe gesture detector
// Right-to-left bottom-edge swipe recognition over a multitouch event stream.
// ----------------------------------------------------------------------------
// Each input word is one touch event: its kind in s_axis_tuser and its value
// in s_axis_tdata. Every accepted word yields exactly one result word in the
// next cycle, and a new word is taken every cycle while the result register
// is empty or being drained; the whole event update is one pass of compare
// logic feeding the state and result registers. A point is checked as soon
// as both an X and a Y position have arrived; fire is raised once per touch
// when the third gate is crossed. Slot events and a tracking id of -1 rearm
// the gates, suspend and resume events pause detection. The user writes registers
// through the always-ready cfg port only while the stream is idle; not enforced.
// ----------------------------------------------------------------------------
module swipe_gesture_detector_top
    import sgd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // event stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [VALUE_W-1:0]   s_axis_tdata,   // [15:0] event_value
    input  logic [MODE_W-1:0]    s_axis_tuser,   // [2:0] mode
    // result stream out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] fire, [2:1] gate_progress,
                                                 // [3] touch_active, [7:4] zero
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [INDEX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    sgd_cfg_t                   cfg_reg;
    sgd_gates_t                 gates_reg;
    sgd_gates_t                 gates_next;
    sgd_gates_t                 eval_gates;
    logic signed [VALUE_W-1:0]  held_x_reg;
    logic signed [VALUE_W-1:0]  held_x_next;
    logic signed [VALUE_W-1:0]  held_y_reg;
    logic signed [VALUE_W-1:0]  held_y_next;
    logic                       x_seen_reg;
    logic                       x_seen_next;
    logic                       y_seen_reg;
    logic                       y_seen_next;
    logic                       asleep_reg;
    logic                       asleep_next;
    logic                       eval_fire;
    logic                       fire_next;
    logic                       accept;
    logic                       gate_reset;
    logic signed [VALUE_W-1:0]  in_value;
    logic [MODE_W-1:0]          in_mode;
    logic                       out_valid_reg;
    logic                       out_fire_reg;
    logic [1:0]                 out_progress_reg;
    logic                       out_touch_reg;

    assign in_value = $signed(s_axis_tdata);
    assign in_mode  = s_axis_tuser;

    // handshakes
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_enable  <= RST_DETECT_ENABLE;
            cfg_reg.bottom_y_limit <= RST_BOTTOM_Y_LIMIT;
            cfg_reg.x_span_max     <= RST_X_SPAN_MAX;
            cfg_reg.x_band_width   <= RST_X_BAND_WIDTH;
            cfg_reg.x_final_edge   <= RST_X_FINAL_EDGE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DETECT_ENABLE:  cfg_reg.detect_enable  <= cfg_data[ENABLE_W-1:0];
                REG_BOTTOM_Y_LIMIT: cfg_reg.bottom_y_limit <= cfg_data;
                REG_X_SPAN_MAX:     cfg_reg.x_span_max     <= cfg_data;
                REG_X_BAND_WIDTH:   cfg_reg.x_band_width   <= cfg_data;
                REG_X_FINAL_EDGE:   cfg_reg.x_final_edge   <= cfg_data;
                default: ;
            endcase
        end
    end

    // gate evaluation on the point as it stands after this word
    sgd_gate_eval u_gate_eval (
        .x             (held_x_next),
        .y             (held_y_next),
        .cfg           (cfg_reg),
        .screen_asleep (asleep_reg),
        .gates_in      (gates_reg),
        .gates_out     (eval_gates),
        .fire          (eval_fire)
    );

    assign gate_reset = (in_mode == MODE_SLOT) ||
                        ((in_mode == MODE_TRACK) && (in_value == TRACK_ID_NONE));

    // next state for one event word
    always_comb begin
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        x_seen_next = x_seen_reg;
        y_seen_next = y_seen_reg;
        asleep_next = asleep_reg;
        gates_next  = gates_reg;
        fire_next   = 1'b0;
        if (in_mode == MODE_POS_X) begin
            held_x_next = in_value;
        end
        if (in_mode == MODE_POS_Y) begin
            held_y_next = in_value;
        end
        priority if (gate_reset) begin
            held_x_next            = held_x_reg;
            held_y_next            = held_y_reg;
            gates_next.first_gate  = 1'b0;
            gates_next.second_gate = 1'b0;
            gates_next.fire_armed  = 1'b1;
            gates_next.touch_flag  = 1'b0;
        end else if (in_mode == MODE_SUSPEND) begin
            asleep_next = 1'b1;
        end else if (in_mode == MODE_RESUME) begin
            asleep_next = 1'b0;
        end else begin
            x_seen_next = x_seen_reg || (in_mode == MODE_POS_X);
            y_seen_next = y_seen_reg || (in_mode == MODE_POS_Y);
            if (x_seen_next && y_seen_next) begin
                x_seen_next = 1'b0;
                y_seen_next = 1'b0;
                gates_next  = eval_gates;
                fire_next   = eval_fire;
            end
        end
    end

    // touch state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_seen_reg            <= 1'b0;
            y_seen_reg            <= 1'b0;
            asleep_reg            <= 1'b0;
            gates_reg.first_gate  <= 1'b0;
            gates_reg.second_gate <= 1'b0;
            gates_reg.fire_armed  <= 1'b1;
            gates_reg.touch_flag  <= 1'b0;
        end else if (accept) begin
            x_seen_reg <= x_seen_next;
            y_seen_reg <= y_seen_next;
            asleep_reg <= asleep_next;
            gates_reg  <= gates_next;
        end
    end

    // held coordinates, only read once written
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_fire_reg     <= fire_next;
            out_progress_reg <= {1'b0, gates_next.first_gate} +
                                {1'b0, gates_next.second_gate};
            out_touch_reg    <= gates_next.touch_flag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_touch_reg, out_progress_reg, out_fire_reg};

    // a fired result always reports both gates passed
    a_fire_full_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_fire_reg) |-> (out_progress_reg == 2'd2))
        else $error("fire reported without both gates passed");

    // firing disarms until the next gate reset
    a_fire_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_fire_reg) |-> !gates_reg.fire_armed)
        else $error("gate still armed after fire");

    // the second gate is only reached through the first
    a_gate_order: assert property (@(posedge aclk) disable iff (!aresetn)
        gates_reg.second_gate |-> gates_reg.first_gate)
        else $error("second gate set without first gate");

    // no gate progress without an evaluated touch
    a_touch_gates: assert property (@(posedge aclk) disable iff (!aresetn)
        !gates_reg.touch_flag |-> (!gates_reg.first_gate && !gates_reg.second_gate))
        else $error("gate progress without active touch");

endmodule
